/* rtl/gap_packet_pacing_scheduler_defines.svh */
// Assertion macros used by the checker file of the transmit pacer.
`ifndef GAP_PACKET_PACING_SCHEDULER_DEFINES_SVH
`define GAP_PACKET_PACING_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define GPPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GPPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/gpps_pkg.sv */
// Shared constants and types of the transmit pacer.
package gpps_pkg;

    localparam int NUM_CLASSES = 8;
    localparam int CLS_W       = 3;
    localparam int RATE_W      = 34;
    localparam int LEN_W       = 14;
    localparam int CLK_W       = 64;
    localparam int DIV_W       = RATE_W + LEN_W + 1;

    localparam int CHECK_BYTES    = 4;
    localparam int PREAMBLE_BYTES = 8;
    localparam int GAP_FLOOR      = 64;

    localparam logic [RATE_W-1:0] RATE_FLOOR        = 34'd1000;
    localparam logic [RATE_W-1:0] LINE_RATE_RESET   = 34'd125000000;
    localparam logic [7:0]        IFG_RESET         = 8'd12;
    localparam logic [LEN_W-1:0]  FRAME_LIMIT_RESET = 14'd1514;

    // Class mode codes.
    localparam logic [1:0] MODE_UNUSED = 2'd0;
    localparam logic [1:0] MODE_NORMAL = 2'd1;
    localparam logic [1:0] MODE_PACED  = 2'd2;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_LINE_RATE    = 3'd0,
        REG_IFG          = 3'd1,
        REG_FRAME_LIMIT  = 3'd2,
        REG_CLASS_SELECT = 3'd3,
        REG_CLASS_RATE   = 3'd4,
        REG_CLASS_MODE   = 3'd5
    } t_reg_idx;

    // Sequencer states.
    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_REP_MUL  = 8'b0000_0010,
        S_REP_DIV  = 8'b0000_0100,
        S_REP_FIN  = 8'b0000_1000,
        S_SEL_SCAN = 8'b0001_0000,
        S_SEL_PROC = 8'b0010_0000,
        S_SEL_RR   = 8'b0100_0000,
        S_SEL_OUT  = 8'b1000_0000
    } t_state;

    typedef logic [NUM_CLASSES-1:0][CLS_W-1:0] t_order;

endpackage

/* rtl/gap_packet_pacing_scheduler.sv */
// Top level of the byte-clock transmit pacer.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready   i_kind, i_active_mask, i_sent_class,
//                                                i_sent_length
//  out      output     o_out_valid / i_out_ready o_grant_gap, o_granted_class, o_gap_bytes
//  cfg      input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A report item for a class that is not paced ends after the link clock advance; a paced
// class goes on through the 49-step restoring divider that works out the inter-packet gap.
// A select item runs up to eight priority rounds, each a scan through one comparator and a
// visit of the chosen class, then a last scan through that comparator, up to eight
// round-robin steps and one output step.
// Reset is synchronous and active low and puts every table at its reset value at once.
// A finished select result waits in the output register; the block takes the next item
// while it waits, but holds the following result until the register is free.
module gap_packet_pacing_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_active_mask,
    input  logic [2:0]  i_sent_class,
    input  logic [13:0] i_sent_length,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_grant_gap,
    output logic [2:0]  o_granted_class,
    output logic [13:0] o_gap_bytes,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [33:0] i_cfg_data
);

    gpps_pkg::t_state r_state;

    // Configuration registers.
    logic [gpps_pkg::RATE_W-1:0] r_line_rate;
    logic [7:0]                  r_ifg;
    logic [gpps_pkg::LEN_W-1:0]  r_frame_limit;
    logic [gpps_pkg::CLS_W-1:0]  r_class_select;

    // Clocks and class tables.
    logic [gpps_pkg::CLK_W-1:0]       r_qclk;
    logic [gpps_pkg::CLK_W-1:0]       r_cclk [gpps_pkg::NUM_CLASSES];
    logic [gpps_pkg::RATE_W-1:0]      r_rate [gpps_pkg::NUM_CLASSES];
    logic [1:0]                       r_mode [gpps_pkg::NUM_CLASSES];
    logic [gpps_pkg::NUM_CLASSES-1:0] r_mark;
    gpps_pkg::t_order                 r_order;

    // Captured item.
    logic [gpps_pkg::NUM_CLASSES-1:0] r_mask;
    logic [gpps_pkg::CLS_W-1:0]       r_cls;
    logic [gpps_pkg::LEN_W-1:0]       r_len;
    logic [gpps_pkg::LEN_W:0]         r_lenovh;

    // Divider.
    logic [gpps_pkg::DIV_W-1:0]  r_dividend;
    logic [gpps_pkg::RATE_W-1:0] r_divisor;
    logic [gpps_pkg::RATE_W-1:0] r_rem;
    logic [gpps_pkg::DIV_W-1:0]  r_quo;
    logic [5:0]                  r_cnt;

    // Selection scan.
    logic [gpps_pkg::CLS_W-1:0]       r_idx;
    logic [gpps_pkg::NUM_CLASSES-1:0] r_seen;
    logic [gpps_pkg::CLS_W-1:0]       r_best;
    logic                             r_best_vld;
    logic [gpps_pkg::RATE_W-1:0]      r_best_rate;
    logic [gpps_pkg::CLS_W-1:0]       r_found;
    logic                             r_found_vld;
    logic [gpps_pkg::LEN_W-1:0]       r_nearest;

    // Result staging and output register.
    logic                       r_res_gap;
    logic [gpps_pkg::CLS_W-1:0] r_res_cls;
    logic [gpps_pkg::LEN_W-1:0] r_res_bytes;
    logic                       r_out_valid;
    logic                       r_out_gap;
    logic [gpps_pkg::CLS_W-1:0] r_out_cls;
    logic [gpps_pkg::LEN_W-1:0] r_out_bytes;

    // Combinational helpers.
    logic [8:0]                  w_ovh;
    logic [gpps_pkg::LEN_W:0]    w_base;
    logic [gpps_pkg::LEN_W:0]    w_lenovh;
    logic [15:0]                 w_thr;
    logic [gpps_pkg::DIV_W-1:0]  w_prod;
    logic [gpps_pkg::RATE_W:0]   w_rem_sh;
    logic [gpps_pkg::DIV_W-1:0]  w_g;
    logic                        w_cand;
    logic [gpps_pkg::CLK_W-1:0]  w_cc;
    logic [gpps_pkg::CLK_W-1:0]  w_diff;
    logic [gpps_pkg::CLS_W-1:0]  w_oc;
    logic [gpps_pkg::LEN_W-1:0]  w_gap;
    logic [gpps_pkg::CLS_W-1:0]  w_cfg_pos;
    logic [1:0]                  w_cfg_mode;
    logic [gpps_pkg::RATE_W-1:0] w_cfg_rate;

    // Move class c, found at position pos, to the round-robin tail.
    function automatic gpps_pkg::t_order f_to_tail(gpps_pkg::t_order ord,
                                                   logic [gpps_pkg::CLS_W-1:0] c,
                                                   logic [gpps_pkg::CLS_W-1:0] pos);
        gpps_pkg::t_order res;
        res = ord;
        for (int p = 0; p < gpps_pkg::NUM_CLASSES - 1; p++) begin
            if (gpps_pkg::CLS_W'(p) >= pos) begin
                res[p] = ord[p+1];
            end
        end
        res[gpps_pkg::NUM_CLASSES-1] = c;
        return res;
    endfunction

    // Wire overhead and report arithmetic.
    assign w_ovh    = 9'(gpps_pkg::PREAMBLE_BYTES) + 9'(r_ifg) + 9'(gpps_pkg::CHECK_BYTES);
    assign w_base   = 15'(r_len) + 15'(gpps_pkg::CHECK_BYTES);
    assign w_lenovh = 15'(r_len) + 15'(w_ovh);
    assign w_thr    = 16'(w_base) + 16'(gpps_pkg::PREAMBLE_BYTES) + 16'(r_ifg);
    assign w_prod   = r_line_rate * w_base;
    assign w_rem_sh = {r_rem, r_dividend[gpps_pkg::DIV_W-1]};
    assign w_g      = (r_quo > gpps_pkg::DIV_W'(w_thr)) ? r_quo - gpps_pkg::DIV_W'(w_thr) : '0;

    // Priority scan: one rate compare per cycle against the best so far.
    assign w_cand = (r_mode[r_idx] == gpps_pkg::MODE_PACED) && !r_seen[r_idx] &&
                    (!r_best_vld || (r_rate[r_idx] > r_best_rate));
    assign w_cc   = r_cclk[r_best];
    assign w_diff = w_cc - r_qclk;

    // Round-robin position and gap frame size.
    assign w_oc  = r_order[r_idx];
    assign w_gap = (r_nearest > 14'(w_ovh)) ? r_nearest - 14'(w_ovh) : '0;

    // Configuration decode helpers.
    assign w_cfg_mode = i_cfg_data[1:0];
    assign w_cfg_rate = (i_cfg_data < gpps_pkg::RATE_FLOOR) ? gpps_pkg::RATE_FLOOR : i_cfg_data;
    always_comb begin
        w_cfg_pos = '0;
        for (int p = 0; p < gpps_pkg::NUM_CLASSES; p++) begin
            if (r_order[p] == r_class_select) begin
                w_cfg_pos = gpps_pkg::CLS_W'(p);
            end
        end
    end

    // Sequencer, tables and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= gpps_pkg::S_IDLE;
            r_line_rate    <= gpps_pkg::LINE_RATE_RESET;
            r_ifg          <= gpps_pkg::IFG_RESET;
            r_frame_limit  <= gpps_pkg::FRAME_LIMIT_RESET;
            r_class_select <= '0;
            r_qclk         <= '0;
            r_mark         <= '0;
            r_out_valid    <= 1'b0;
            for (int c = 0; c < gpps_pkg::NUM_CLASSES; c++) begin
                r_cclk[c]  <= '0;
                r_rate[c]  <= gpps_pkg::RATE_FLOOR;
                r_mode[c]  <= gpps_pkg::MODE_UNUSED;
                r_order[c] <= gpps_pkg::CLS_W'(c);
            end
        end else begin
            // A taken result frees the output register unless a new one is loaded.
            if (r_out_valid && i_out_ready && (r_state != gpps_pkg::S_SEL_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                gpps_pkg::S_IDLE: begin
                    if (i_in_valid) begin
                        r_mask      <= i_active_mask;
                        r_cls       <= i_sent_class;
                        r_len       <= i_sent_length;
                        r_idx       <= '0;
                        r_seen      <= '0;
                        r_best_vld  <= 1'b0;
                        r_found_vld <= 1'b0;
                        r_nearest   <= r_frame_limit;
                        r_state     <= i_kind ? gpps_pkg::S_REP_MUL : gpps_pkg::S_SEL_SCAN;
                    end
                end

                // Link clock advance and divider setup.
                gpps_pkg::S_REP_MUL: begin
                    r_qclk     <= r_qclk + gpps_pkg::CLK_W'(w_lenovh);
                    r_lenovh   <= w_lenovh;
                    r_dividend <= w_prod;
                    r_divisor  <= r_rate[r_cls];
                    r_rem      <= '0;
                    r_cnt      <= 6'(gpps_pkg::DIV_W - 1);
                    r_state    <= (r_mode[r_cls] == gpps_pkg::MODE_PACED) ?
                                  gpps_pkg::S_REP_DIV : gpps_pkg::S_IDLE;
                end

                // Restoring division, one quotient bit per cycle.
                gpps_pkg::S_REP_DIV: begin
                    if (w_rem_sh >= {1'b0, r_divisor}) begin
                        r_rem <= gpps_pkg::RATE_W'(w_rem_sh - {1'b0, r_divisor});
                        r_quo <= {r_quo[gpps_pkg::DIV_W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh[gpps_pkg::RATE_W-1:0];
                        r_quo <= {r_quo[gpps_pkg::DIV_W-2:0], 1'b0};
                    end
                    r_dividend <= {r_dividend[gpps_pkg::DIV_W-2:0], 1'b0};
                    r_cnt      <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_state <= gpps_pkg::S_REP_FIN;
                    end
                end

                // Class clock update: restart from the link clock when marked.
                gpps_pkg::S_REP_FIN: begin
                    if (r_mark[r_cls]) begin
                        r_mark[r_cls] <= 1'b0;
                        r_cclk[r_cls] <= r_qclk + gpps_pkg::CLK_W'(w_g);
                    end else begin
                        r_cclk[r_cls] <= r_cclk[r_cls] + gpps_pkg::CLK_W'(r_lenovh) +
                                         gpps_pkg::CLK_W'(w_g);
                    end
                    r_state <= gpps_pkg::S_IDLE;
                end

                // Find the fastest paced class not yet visited.
                gpps_pkg::S_SEL_SCAN: begin
                    if (w_cand) begin
                        r_best      <= r_idx;
                        r_best_rate <= r_rate[r_idx];
                        r_best_vld  <= 1'b1;
                    end
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'(gpps_pkg::NUM_CLASSES - 1)) begin
                        r_state <= (r_best_vld || w_cand) ?
                                   gpps_pkg::S_SEL_PROC : gpps_pkg::S_SEL_RR;
                    end
                end

                // Visit the chosen class: deadline, reset mark or grant.
                gpps_pkg::S_SEL_PROC: begin
                    if (!r_found_vld && (w_cc > r_qclk)) begin
                        if ((w_diff < gpps_pkg::CLK_W'(r_nearest)) &&
                            (w_diff >= gpps_pkg::CLK_W'(gpps_pkg::GAP_FLOOR))) begin
                            r_nearest <= w_diff[gpps_pkg::LEN_W-1:0];
                        end
                    end else if (!r_mask[r_best]) begin
                        r_mark[r_best] <= 1'b1;
                    end else if (!r_found_vld) begin
                        r_found     <= r_best;
                        r_found_vld <= 1'b1;
                    end
                    r_seen[r_best] <= 1'b1;
                    r_best_vld     <= 1'b0;
                    r_state        <= gpps_pkg::S_SEL_SCAN;
                end

                // Round-robin walk, then the gap frame if nothing is granted.
                gpps_pkg::S_SEL_RR: begin
                    if (r_found_vld) begin
                        r_res_gap   <= 1'b0;
                        r_res_cls   <= r_found;
                        r_res_bytes <= '0;
                        r_state     <= gpps_pkg::S_SEL_OUT;
                    end else if ((r_mode[w_oc] == gpps_pkg::MODE_NORMAL) && r_mask[w_oc]) begin
                        r_order     <= f_to_tail(r_order, w_oc, r_idx);
                        r_res_gap   <= 1'b0;
                        r_res_cls   <= w_oc;
                        r_res_bytes <= '0;
                        r_state     <= gpps_pkg::S_SEL_OUT;
                    end else if (r_idx == 3'(gpps_pkg::NUM_CLASSES - 1)) begin
                        r_qclk      <= r_qclk + gpps_pkg::CLK_W'(w_gap) +
                                       gpps_pkg::CLK_W'(w_ovh);
                        r_res_gap   <= 1'b1;
                        r_res_cls   <= '0;
                        r_res_bytes <= w_gap;
                        r_state     <= gpps_pkg::S_SEL_OUT;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                    end
                end

                // Hand the result to the output register once it is free.
                gpps_pkg::S_SEL_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_gap   <= r_res_gap;
                        r_out_cls   <= r_res_cls;
                        r_out_bytes <= r_res_bytes;
                        r_state     <= gpps_pkg::S_IDLE;
                    end
                end

                default: begin
                    r_state <= gpps_pkg::S_IDLE;
                end
            endcase

            // The user must issue configuration writes only while the block is idle; the block does not enforce it.
            if (i_cfg_we) begin
                unique case (gpps_pkg::t_reg_idx'(i_cfg_idx))
                    gpps_pkg::REG_LINE_RATE:    r_line_rate    <= i_cfg_data;
                    gpps_pkg::REG_IFG:          r_ifg          <= i_cfg_data[7:0];
                    gpps_pkg::REG_FRAME_LIMIT:  r_frame_limit  <= i_cfg_data[13:0];
                    gpps_pkg::REG_CLASS_SELECT: r_class_select <= i_cfg_data[2:0];
                    gpps_pkg::REG_CLASS_RATE:   r_rate[r_class_select] <= w_cfg_rate;
                    gpps_pkg::REG_CLASS_MODE: begin
                        if ((w_cfg_mode == gpps_pkg::MODE_UNUSED) ||
                            (w_cfg_mode == gpps_pkg::MODE_NORMAL) ||
                            (w_cfg_mode == gpps_pkg::MODE_PACED)) begin
                            r_mode[r_class_select] <= w_cfg_mode;
                        end
                        if (w_cfg_mode == gpps_pkg::MODE_NORMAL) begin
                            r_order <= f_to_tail(r_order, r_class_select, w_cfg_pos);
                        end
                        if (w_cfg_mode == gpps_pkg::MODE_PACED) begin
                            r_mark[r_class_select] <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_in_ready      = (r_state == gpps_pkg::S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_grant_gap     = r_out_gap;
    assign o_granted_class = r_out_cls;
    assign o_gap_bytes     = r_out_bytes;

endmodule

/* rtl/gpps_checker.sv */
// Port-level checker for the transmit pacer, bound to the top level.
`include "gap_packet_pacing_scheduler_defines.svh"

module gpps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_grant_gap,
    input logic [2:0]  o_granted_class,
    input logic [13:0] o_gap_bytes
);

    // A waiting result stays offered and unchanged.
    `GPPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_gap_bytes) && $stable(o_granted_class), "result dropped or changed while stalled")

    // A gap result names no class.
    `GPPS_ASSERT_NOW(a_gap_no_class, i_clk, i_rst_n, o_out_valid && o_grant_gap, o_granted_class == 3'd0, "gap result carries a class")

    // A class grant carries no gap size.
    `GPPS_ASSERT_NOW(a_grant_no_gap, i_clk, i_rst_n, o_out_valid && !o_grant_gap, o_gap_bytes == 14'd0, "class grant carries gap bytes")

    // Every accepted item takes the block out of idle, so ready falls after the transfer.
    `GPPS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready after a transfer")

endmodule

bind gap_packet_pacing_scheduler gpps_checker u_gpps_checker (.*);
